// File: rtl/rxfdm_pkg.sv
// ----------------------------------------------------------------------------
// rxfdm_pkg
// Shared types and constants for the receive FIFO with delimiter matching.
// ----------------------------------------------------------------------------
`default_nettype none

package rxfdm_pkg;

  localparam int BYTE_W = 8;
  localparam int COUNT_W = 6;
  localparam int DCOUNT_W = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int DELIM_REGS = 4;
  localparam int OP_W = 2;

  localparam int SLOTS_DEFAULT = 64;
  localparam int DELIMITER_SLOTS_DEFAULT = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  localparam logic [OP_W-1:0] OP_LINK = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_ARM = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_A = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_B = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_C = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_D = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              hit;
  } rxfdm_link_t;

endpackage

`default_nettype wire

// File: rtl/rxfdm_cell.sv
// ----------------------------------------------------------------------------
// rxfdm_cell
// One compare cell: checks the passing byte against its delimiter and hands
// the byte and the running hit flag to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rxfdm_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rxfdm_pkg::rxfdm_link_t     link_in,
  input  wire logic [rxfdm_pkg::BYTE_W-1:0] delim,
  input  wire logic                       active,
  output rxfdm_pkg::rxfdm_link_t          link_out
);
  import rxfdm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
    end else begin
      link_out.valid <= link_in.valid;
    end
    link_out.data <= link_in.data;
    link_out.hit <= link_in.hit | (active & (link_in.data == delim));
  end

endmodule

`default_nettype wire

// File: rtl/rx_fifo_with_delimiter_match.sv
// ----------------------------------------------------------------------------
// rx_fifo_with_delimiter_match
// Receive ring FIFO with delimiter and count matching.
// ----------------------------------------------------------------------------
// Busy is high from the accepting edge while the byte travels the row of
// delimiter compare cells, one cell per cycle, and the result is shown
// with done for a single cycle in which busy is already low, so a new
// item can be accepted at the edge that ends it. The receiver cannot stall,
// so it must take each result in that cycle. The ring holds at most
// SLOTS - 1 bytes.
`default_nettype none

module rx_fifo_with_delimiter_match #(
  parameter int SLOTS = rxfdm_pkg::SLOTS_DEFAULT,
  parameter int DELIMITER_SLOTS = rxfdm_pkg::DELIMITER_SLOTS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [rxfdm_pkg::OP_W-1:0]      operation,
  input  wire logic [rxfdm_pkg::BYTE_W-1:0]    data_byte,
  input  wire logic [rxfdm_pkg::COUNT_W-1:0]   match_count,
  output logic                                 done,
  output logic [rxfdm_pkg::BYTE_W-1:0]         read_data,
  output logic                                 read_valid,
  output logic                                 rx_full,
  output logic                                 delimiter_hit,
  output logic                                 count_hit,
  output logic [rxfdm_pkg::COUNT_W-1:0]        buffered_count,
  input  wire logic                            cfg_write_en,
  input  wire logic [rxfdm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rxfdm_pkg::BYTE_W-1:0]    cfg_data
);
  import rxfdm_pkg::*;

  localparam int PTR_W = $clog2(SLOTS);

  logic [BYTE_W-1:0]   mem [SLOTS];
  logic [BYTE_W-1:0]   rd_q;

  logic [PTR_W-1:0]    wp;
  logic [PTR_W-1:0]    rp;
  logic [PTR_W-1:0]    armed;
  logic                armed_valid;
  logic [DCOUNT_W-1:0] delim_count;
  logic [BYTE_W-1:0]   delims [DELIM_REGS];

  logic                p_rvalid;
  logic                p_full;
  logic                p_stored;
  logic                p_chit;
  logic [COUNT_W-1:0]  p_count;

  logic                accept;
  logic [PTR_W-1:0]    wp_inc;
  logic [PTR_W-1:0]    rp_inc;
  logic [PTR_W-1:0]    wp_next;
  logic [PTR_W-1:0]    rp_next;
  logic [PTR_W-1:0]    armed_next;
  logic                armed_valid_next;
  logic                full_now;
  logic                stored_now;
  logic                rvalid_now;
  logic                chit_now;
  logic [PTR_W-1:0]    held;
  logic [COUNT_W-1:0]  count_next;
  logic [PTR_W:0]      arm_sum;
  logic [PTR_W-1:0]    arm_pos;
  logic [PTR_W-1:0]    cnt_mod_tab [2**COUNT_W];

  rxfdm_link_t         chain [DELIMITER_SLOTS+1];

  assign accept = start & ~busy;

  for (genvar g = 0; g < 2**COUNT_W; g++) begin : g_cnt_mod
    assign cnt_mod_tab[g] = PTR_W'(g % SLOTS);
  end

  assign wp_inc = (wp == PTR_W'(SLOTS - 1)) ? '0 : wp + PTR_W'(1);
  assign rp_inc = (rp == PTR_W'(SLOTS - 1)) ? '0 : rp + PTR_W'(1);
  assign arm_sum = {1'b0, wp} + {1'b0, cnt_mod_tab[match_count]};
  assign arm_pos = (arm_sum >= (PTR_W+1)'(SLOTS)) ?
                   PTR_W'(arm_sum - (PTR_W+1)'(SLOTS)) : PTR_W'(arm_sum);

  always_comb begin
    wp_next = wp;
    rp_next = rp;
    armed_next = armed;
    armed_valid_next = armed_valid;
    full_now = 1'b0;
    stored_now = 1'b0;
    rvalid_now = 1'b0;
    chit_now = 1'b0;
    unique case (operation)
      OP_LINK: begin
        if (wp_inc != rp) begin
          stored_now = 1'b1;
          wp_next = wp_inc;
          if (armed_valid && (wp_inc == armed)) begin
            armed_valid_next = 1'b0;
            chit_now = 1'b1;
          end
        end else begin
          full_now = 1'b1;
        end
      end
      OP_READ: begin
        if (rp != wp) begin
          rvalid_now = 1'b1;
          rp_next = rp_inc;
        end
      end
      OP_ARM: begin
        armed_next = arm_pos;
        armed_valid_next = 1'b1;
      end
      OP_NONE: begin
      end
    endcase
  end

  always_comb begin
    if (wp_next >= rp_next) begin
      held = wp_next - rp_next;
    end else begin
      held = PTR_W'({1'b0, wp_next} + (PTR_W+1)'(SLOTS) - {1'b0, rp_next});
    end
    if (9'(held) > 9'(COUNT_MAX)) begin
      count_next = COUNT_MAX;
    end else begin
      count_next = COUNT_W'(held);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && stored_now) begin
      mem[wp] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rvalid_now) begin
      rd_q <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      armed <= '0;
      armed_valid <= 1'b0;
    end else if (accept) begin
      wp <= wp_next;
      rp <= rp_next;
      armed <= armed_next;
      armed_valid <= armed_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_rvalid <= rvalid_now;
      p_full <= full_now;
      p_stored <= stored_now;
      p_chit <= chit_now;
      p_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_count <= '0;
      for (int i = 0; i < DELIM_REGS; i++) begin
        delims[i] <= '0;
      end
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_DELIM_COUNT: delim_count <= cfg_data[DCOUNT_W-1:0];
        REG_DELIM_A:     delims[0] <= cfg_data;
        REG_DELIM_B:     delims[1] <= cfg_data;
        REG_DELIM_C:     delims[2] <= cfg_data;
        REG_DELIM_D:     delims[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign chain[0].valid = accept;
  assign chain[0].data = data_byte;
  assign chain[0].hit = 1'b0;

  for (genvar g = 0; g < DELIMITER_SLOTS; g++) begin : g_cell
    logic [BYTE_W-1:0] cell_delim;
    logic              cell_active;
    if (g < DELIM_REGS) begin : g_live
      assign cell_delim = delims[g];
      assign cell_active = delim_count > DCOUNT_W'(g);
    end else begin : g_idle
      assign cell_delim = '0;
      assign cell_active = 1'b0;
    end
    rxfdm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .link_in  (chain[g]),
      .delim    (cell_delim),
      .active   (cell_active),
      .link_out (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (chain[DELIMITER_SLOTS].valid) begin
        busy <= 1'b0;
      end
      done <= chain[DELIMITER_SLOTS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chain[DELIMITER_SLOTS].valid) begin
      read_data <= p_rvalid ? rd_q : '0;
      read_valid <= p_rvalid;
      rx_full <= p_full;
      delimiter_hit <= p_stored & chain[DELIMITER_SLOTS].hit;
      count_hit <= p_chit;
      buffered_count <= p_count;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rxfdm_checker.sv
// ----------------------------------------------------------------------------
// rxfdm_checker
// Port-level checks for the receive FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rxfdm_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done,
  input wire logic [rxfdm_pkg::BYTE_W-1:0]      read_data,
  input wire logic                              read_valid,
  input wire logic                              rx_full,
  input wire logic                              delimiter_hit,
  input wire logic                              count_hit
);
  import rxfdm_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an item was accepted");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    done && !read_valid |-> read_data == '0)
    else $error("read data is not zero without a popped byte");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({read_valid, rx_full, delimiter_hit | count_hit}))
    else $error("result flags from more than one kind of item");

endmodule

bind rx_fifo_with_delimiter_match rxfdm_checker u_rxfdm_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .read_data     (read_data),
  .read_valid    (read_valid),
  .rx_full       (rx_full),
  .delimiter_hit (delimiter_hit),
  .count_hit     (count_hit)
);

`default_nettype wire
